@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hdl/cdh_pkg.sv @@
// ----------------------------------------------------------------------------
// cdh_pkg
// Shared constants and codes of the cube deduplication table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package cdh_pkg;
  localparam int unsigned TableSlots  = 1024;
  localparam int unsigned MaxEntries  = 512;
  localparam int unsigned OutputCount = 64;
  localparam int unsigned SlotW  = $clog2(TableSlots);
  localparam int unsigned IdW    = $clog2(MaxEntries);
  localparam int unsigned CntW   = IdW + 1;
  localparam int unsigned OwnW   = 6;
  localparam int unsigned OcntW  = 7;
  localparam int unsigned MinCapacity = 8;
  localparam logic [63:0] FnvBasis = 64'd1469598103934665603;
  localparam logic [63:0] FnvPrime = 64'd1099511628211;
  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StInserted = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StCleared  = 2'd3;
  // Slot word: valid bit over id
  localparam int unsigned SlotEntW = IdW + 1;
  // Entry word: pos1,pos0,val1,val0
  localparam int unsigned EntW = 256;
  // Owner word: count over last owner
  localparam int unsigned OwnEntW = OcntW + OwnW;
endpackage

@@ hdl/cdh_ram.sv @@
// ----------------------------------------------------------------------------
// cdh_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cdh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/cdh_hash.sv @@
// ----------------------------------------------------------------------------
// cdh_hash
// Iterative FNV-1a-style unit (FNV prime, non-standard basis): one xor and
// one 64-bit multiply per step, the multiply split into 32x32 partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cdh_hash import cdh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  steps_i,   // 2 or 4 xor-multiply steps
  input  logic [63:0] w0_i,
  input  logic [63:0] w1_i,
  input  logic [63:0] w2_i,
  input  logic [63:0] w3_i,
  output logic        done_o,
  output logic [63:0] hash_o
);
  logic [63:0] h_q, h_d, x_q, x_d, acc_q, acc_d;
  logic [2:0]  step_q, step_d;
  logic [1:0]  ph_q, ph_d;
  logic        run_q, run_d;
  logic [63:0] word;
  logic [31:0] a_part, b_part;
  logic [63:0] prod;

  always_comb begin
    case (step_q[1:0])
      2'd0: word = w0_i;
      2'd1: word = w1_i;
      2'd2: word = w2_i;
      default: word = w3_i;
    endcase
  end

  // Partial product selection: lo*lo, lo*hi, hi*lo (hi*hi drops out mod 2^64)
  always_comb begin
    case (ph_q)
      2'd1: begin a_part = x_q[31:0];  b_part = FnvPrime[31:0];  end
      2'd2: begin a_part = x_q[31:0];  b_part = FnvPrime[63:32]; end
      default: begin a_part = x_q[63:32]; b_part = FnvPrime[31:0]; end
    endcase
    prod = 64'(a_part) * 64'(b_part);
  end

  always_comb begin
    h_d = h_q; x_d = x_q; acc_d = acc_q; step_d = step_q; ph_d = ph_q;
    run_d = run_q; done_o = 1'b0;
    if (start_i) begin
      h_d = FnvBasis; step_d = '0; ph_d = 2'd0; run_d = 1'b1;
    end else if (run_q) begin
      case (ph_q)
        2'd0: begin x_d = h_q ^ word; acc_d = '0; ph_d = 2'd1; end
        2'd1: begin acc_d = prod; ph_d = 2'd2; end
        2'd2: begin acc_d = acc_q + {prod[31:0], 32'd0}; ph_d = 2'd3; end
        default: begin
          h_d = acc_q + {prod[31:0], 32'd0};
          ph_d = 2'd0;
          step_d = step_q + 3'd1;
          if (step_q + 3'd1 == steps_i) begin
            run_d = 1'b0;
            done_o = 1'b1;
          end
        end
      endcase
    end
  end

  assign hash_o = h_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; step_q <= '0; ph_q <= '0;
    end else begin
      run_q <= run_d; step_q <= step_d; ph_q <= ph_d;
    end
  end
  always_ff @(posedge clk_i) begin
    h_q <= h_d; x_q <= x_d; acc_q <= acc_d;
  end
endmodule

@@ hdl/cube_dedup_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// cube_dedup_hash_table_top
// Cube deduplication table: FNV-1a-style hash, linear probing over a slot RAM.
// ----------------------------------------------------------------------------
// Hold start high with an item until busy is low; the item is taken at that
// edge. An insert hashes the words in use through one iterative FNV unit
// (two xor-multiply steps per word pair), then probes the slot RAM one slot
// at a time (slot read, slot check, entry compare). An insert that ends at
// an empty slot shows its result after the slot check, one that meets a
// matching cube after the entry compare; busy falls in the cycle after the
// result. Every further slot visited adds another slot read, slot check and
// entry compare. A clear sweeps the 1024-entry slot RAM one slot per cycle,
// then shows its result; the next item can be taken in the cycle after the
// result. The same sweep runs once after reset before busy first falls. Each
// result is shown for exactly one cycle with done_o high; the receiver
// cannot stall it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cube_dedup_hash_table_top import cdh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [5:0]  output_index_i,
  input  logic [63:0] pos_word0_i,
  input  logic [63:0] pos_word1_i,
  input  logic [63:0] val_word0_i,
  input  logic [63:0] val_word1_i,
  output logic        done_o,
  output logic [8:0]  cube_id_o,
  output logic [1:0]  status_o,
  output logic [6:0]  owner_count_o,
  output logic [9:0]  distinct_count_o,
  output logic [9:0]  shared_count_o
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_HASH = 4'd2,
    S_SRD = 4'd3, S_SCHK = 4'd4, S_ECMP = 4'd6, S_OUT = 4'd7;

  logic [3:0] st_q, st_d;
  logic [9:0]  cap_q;
  logic [1:0]  wiu_q;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW:0]   probes_q, probes_d;
  logic [CntW-1:0]  ent_q, ent_d, shr_q, shr_d;
  logic        op_q;
  logic [5:0]  own_q;
  logic [63:0] p0_q, p1_q, v0_q, v1_q;
  logic [IdW-1:0] id_q, id_d;
  logic [1:0]  stat_q, stat_d;
  logic [6:0]  cnt_q, cnt_d;

  // Effective settings
  logic [CntW-1:0] eff_cap;
  logic two_words;
  always_comb begin
    eff_cap = (cap_q < 10'(MinCapacity)) ? CntW'(MinCapacity)
      : (cap_q > 10'(MaxEntries)) ? CntW'(MaxEntries) : CntW'(cap_q);
    two_words = (wiu_q >= 2'd2);
  end

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      1'b0: prdata = {22'd0, cap_q};
      default: prdata = {30'd0, wiu_q};
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 10'd512; wiu_q <= 2'd2;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) cap_q <= pwdata[9:0];
      else if (paddr == 3'd4) wiu_q <= pwdata[1:0];
    end
  end

  // Hash unit
  logic hstart, hdone;
  logic [63:0] hash;
  cdh_hash u_hash (
    .clk_i, .rst_ni, .start_i(hstart),
    .steps_i(two_words ? 3'd4 : 3'd2),
    .w0_i(p0_q), .w1_i(v0_q), .w2_i(p1_q), .w3_i(v1_q),
    .done_o(hdone), .hash_o(hash)
  );

  // Memories
  logic slot_we; logic [SlotW-1:0] slot_wa, slot_ra;
  logic [SlotEntW-1:0] slot_wd, slot_rd;
  cdh_ram #(.Width(SlotEntW), .Depth(TableSlots)) u_slots (
    .clk_i, .we_i(slot_we), .waddr_i(slot_wa), .wdata_i(slot_wd),
    .raddr_i(slot_ra), .rdata_o(slot_rd));
  logic ent_we; logic [IdW-1:0] ent_wa, ent_ra;
  logic [EntW-1:0] ent_rd;
  cdh_ram #(.Width(EntW), .Depth(MaxEntries)) u_ents (
    .clk_i, .we_i(ent_we), .waddr_i(ent_wa), .wdata_i({p1_q, p0_q, v1_q, v0_q}),
    .raddr_i(ent_ra), .rdata_o(ent_rd));
  logic own_we; logic [OwnEntW-1:0] own_wd, own_rd;
  cdh_ram #(.Width(OwnEntW), .Depth(MaxEntries)) u_own (
    .clk_i, .we_i(own_we), .waddr_i(ent_wa), .wdata_i(own_wd),
    .raddr_i(ent_ra), .rdata_o(own_rd));

  logic slot_valid; logic [IdW-1:0] slot_id;
  assign slot_valid = slot_rd[SlotEntW-1];
  assign slot_id = slot_rd[IdW-1:0];
  assign slot_ra = slot_q;
  assign ent_ra = slot_id;

  logic same;
  always_comb begin
    same = (ent_rd[191:128] == p0_q) && (ent_rd[63:0] == v0_q);
    if (two_words) same = same && (ent_rd[255:192] == p1_q) && (ent_rd[127:64] == v1_q);
  end

  logic [6:0] oc_new; logic [5:0] own_old; logic [6:0] oc_old;
  assign oc_old = own_rd[OwnEntW-1:OwnW];
  assign own_old = own_rd[OwnW-1:0];

  always_comb begin
    st_d = st_q; slot_d = slot_q; probes_d = probes_q; ent_d = ent_q; shr_d = shr_q;
    id_d = id_q; stat_d = stat_q; cnt_d = cnt_q;
    hstart = 1'b0; slot_we = 1'b0; slot_wa = slot_q; slot_wd = '0;
    ent_we = 1'b0; ent_wa = id_q; own_we = 1'b0; own_wd = '0; oc_new = oc_old;
    case (st_q)
      S_IDLE: begin
        if (start) begin
          if (opcode_i) begin
            st_d = S_CLR; slot_d = '0; ent_d = '0; shr_d = '0;
          end else begin
            st_d = S_HASH; hstart = 1'b1;
          end
        end
      end
      S_CLR: begin
        // Sweep one slot per cycle
        slot_we = 1'b1;
        slot_d = slot_q + SlotW'(1);
        if (slot_q == SlotW'(TableSlots - 1)) begin
          st_d = op_q ? S_OUT : S_IDLE;
          id_d = '0; stat_d = StCleared; cnt_d = '0;
        end
      end
      S_HASH: begin
        if (hdone) begin
          slot_d = hash[SlotW-1:0]; probes_d = '0; st_d = S_SRD;
        end
      end
      S_SRD: st_d = S_SCHK;
      S_SCHK: begin
        if (probes_q == (SlotW+1)'(TableSlots)) begin
          id_d = '0; stat_d = StFull; cnt_d = '0; st_d = S_OUT;
        end else if (!slot_valid) begin
          if (ent_q < eff_cap) begin
            id_d = ent_q[IdW-1:0];
            slot_we = 1'b1; slot_wd = {1'b1, ent_q[IdW-1:0]};
            ent_we = 1'b1; ent_wa = ent_q[IdW-1:0];
            own_we = 1'b1; own_wd = {7'd1, own_q};
            ent_d = ent_q + CntW'(1); stat_d = StInserted; cnt_d = 7'd1;
          end else begin
            id_d = '0; stat_d = StFull; cnt_d = '0;
          end
          st_d = S_OUT;
        end else begin
          id_d = slot_id; st_d = S_ECMP;
        end
      end
      S_ECMP: begin
        if (CntW'(id_q) < ent_q && same) begin
          if (own_old != own_q && oc_old < 7'(OutputCount)) oc_new = oc_old + 7'd1;
          if (own_old != own_q) begin
            own_we = 1'b1; own_wd = {oc_new, own_q};
            if (oc_new == 7'd2 && oc_old == 7'd1) shr_d = shr_q + CntW'(1);
          end
          stat_d = StFound; cnt_d = oc_new; st_d = S_OUT;
        end else begin
          slot_d = slot_q + SlotW'(1); probes_d = probes_q + (SlotW+1)'(1); st_d = S_SRD;
        end
      end
      S_OUT: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Capture the item and advance the datapath registers
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && start) begin
      own_q <= output_index_i;
      p0_q <= pos_word0_i; p1_q <= pos_word1_i;
      v0_q <= val_word0_i; v1_q <= val_word1_i;
    end
    id_q <= id_d; stat_q <= stat_d; cnt_q <= cnt_d; probes_q <= probes_d;
  end

  // Start the post-reset sweep from slot zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; slot_q <= '0; ent_q <= '0; shr_q <= '0; op_q <= 1'b0;
    end else begin
      st_q <= st_d; slot_q <= slot_d; ent_q <= ent_d; shr_q <= shr_d;
      if (st_q == S_IDLE && start) op_q <= 1'b1;
    end
  end

  assign busy = (st_q != S_IDLE);
  assign done_o = (st_q == S_OUT);
  assign cube_id_o = id_q;
  assign status_o = stat_q;
  assign owner_count_o = cnt_q;
  assign distinct_count_o = ent_q;
  assign shared_count_o = shr_q;

  `ASSERT_IMP(a_shr_le_ent, clk_i, rst_ni, 1'b1, shr_q <= ent_q)
  `ASSERT_IMP(a_ent_cap, clk_i, rst_ni, st_q == S_OUT && status_o == StInserted,
    ent_q <= eff_cap)
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
endmodule
